>>> rtl/iks_pkg.sv
package iks_pkg;

  // Fixed point: cosines are Q.14, CORDIC angles are Q.20.
  localparam int ONE_Q14 = 16384;

  localparam int DIV_STEPS    = 15;
  localparam int SQRT_STEPS   = 15;
  localparam int CORDIC_STEPS = 20;

  localparam int Z_W  = 25;
  localparam int XY_W = 36;

  localparam logic signed [Z_W-1:0] PI_Q20 = 25'sd3294199;

  localparam logic signed [Z_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396, 25'sd65451,
    25'sd32757,  25'sd16383,  25'sd8192,   25'sd4096,   25'sd2048,
    25'sd1024,   25'sd512,    25'sd256,    25'sd128,    25'sd64,
    25'sd32,     25'sd16,     25'sd8,      25'sd4,      25'sd2
  };

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd2;

  localparam logic [13:0] UPPER_RESET = 14'd1638;
  localparam logic [13:0] LOWER_RESET = 14'd1638;
  localparam logic [15:0] GAIN_RESET  = 16'd2560;

endpackage

>>> rtl/two_link_ik_position_servo.sv
// Throughput: one item per cycle; the chain of two dividers, two square roots and
// two CORDIC units is fully pipelined and the whole pipeline holds while the output waits.
// Reset clears every valid bit and loads the link lengths and gain with their defaults.
module two_link_ik_position_servo import iks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // target_x, target_y, measured_shoulder, measured_elbow
  input  logic [63:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // goal_shoulder, goal_elbow, in_reach, shoulder_speed, elbow_speed, zero fill
  output logic [71:0]           m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] ms;
    logic signed [15:0] me;
    logic [31:0]        r2;
    logic               reach_ok;
  } front_t;

  typedef struct packed {
    front_t             f;
    logic signed [15:0] c;
  } cos_t;

  typedef struct packed {
    front_t             f;
    logic signed [15:0] c;
    logic [14:0]        s;
  } elb_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] ms;
    logic signed [15:0] me;
    logic               reach_ok;
    logic               rz;
    logic signed [15:0] elbow;
  } back_t;

  typedef struct packed {
    back_t              b;
    logic signed [15:0] t;
  } tb_t;

  logic en;

  // Configuration and the products derived from it.
  logic [13:0] l1, l2;
  logic [15:0] gain;
  logic [27:0] l1sq, l2sq, l1l2;
  logic [29:0] reachsq;
  logic [14:0] reach;

  // Front stages.
  logic               va1, va2;
  logic signed [15:0] x1, y1, ms1, me1;
  logic signed [31:0] xx1, yy1;
  front_t             f2;
  logic signed [33:0] n1_2;

  // First divider, root and CORDIC.
  logic               d1_v, q1_v, e1_v;
  logic signed [15:0] d1_c;
  front_t             d1_side;
  cos_t               q1_in, q1_side;
  logic [14:0]        q1_s;
  elb_t               e1_in, e1_side;
  logic signed [15:0] e1_ang;

  // Shoulder numerator stages.
  logic               vc1, vc2, vc3, vc4;
  back_t              bc1, bc2, bc3, bc4;
  logic [31:0]        r2c1, r2c2, r2c3;
  logic signed [30:0] p1c1;
  logic [28:0]        p2c1, p2c2;
  logic signed [31:0] kc2;
  logic signed [47:0] ac3, bpc3, numc4;

  // Second divider, root and CORDIC.
  logic               d2_v, q2_v, e2_v;
  logic signed [15:0] d2_t;
  back_t              d2_side, e2_side;
  tb_t                q2_in, q2_side;
  logic [14:0]        q2_s;
  logic signed [15:0] e2_ys, e2_xs, e2_ang;

  // Speed stages.
  logic               vd1, vd2, vd3;
  logic signed [15:0] sh_d1, el_d1, sh_d2, el_d2, sh_d3, el_d3;
  logic               in_d1, in_d2, in_d3;
  logic signed [16:0] er1_d1, er2_d1;
  logic signed [33:0] pr1_d2, pr2_d2;
  logic signed [33:0] rnd1, rnd2;
  logic signed [15:0] sp1_d3, sp2_d3;
  logic signed [15:0] shoulder;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !rst && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1   <= UPPER_RESET;
      l2   <= LOWER_RESET;
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_UPPER: l1   <= cfg_wdata[13:0];
        CFG_LOWER: l2   <= cfg_wdata[13:0];
        CFG_GAIN:  gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign reach = {1'b0, l1} + {1'b0, l2};

  always_ff @(posedge clk) begin
    l1sq    <= l1 * l1;
    l2sq    <= l2 * l2;
    l1l2    <= l1 * l2;
    reachsq <= reach * reach;
  end

  // Stage A1: squares of the target coordinates.
  always_ff @(posedge clk) begin
    if (rst) begin
      va1 <= 1'b0;
      va2 <= 1'b0;
    end else if (en) begin
      va1 <= s_axis_tvalid;
      va2 <= va1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= s_axis_tdata[15:0];
      y1  <= s_axis_tdata[31:16];
      ms1 <= s_axis_tdata[47:32];
      me1 <= s_axis_tdata[63:48];
      xx1 <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[15:0]);
      yy1 <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
    end
  end

  // Stage A2: radius squared, reach test and the law of cosines numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      f2.x        <= x1;
      f2.y        <= y1;
      f2.ms       <= ms1;
      f2.me       <= me1;
      f2.r2       <= $unsigned(xx1) + $unsigned(yy1);
      f2.reach_ok <= ($unsigned(xx1) + $unsigned(yy1)) < {2'b0, reachsq};
      n1_2        <= $signed({2'b0, $unsigned(xx1) + $unsigned(yy1)})
                     - $signed({6'b0, l1sq}) - $signed({6'b0, l2sq});
    end
  end

  iks_div #(.NW(48), .DW(29), .SW($bits(front_t))) u_div_elbow (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va2),
    .num       ({n1_2, 14'b0}),
    .den       ({l1l2, 1'b0}),
    .in_side   (f2),
    .out_valid (d1_v),
    .quo       (d1_c),
    .out_side  (d1_side)
  );

  assign q1_in.f = d1_side;
  assign q1_in.c = d1_c;

  iks_sqrt #(.SW($bits(cos_t))) u_sqrt_elbow (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_v),
    .cosv      (d1_c),
    .in_side   (q1_in),
    .out_valid (q1_v),
    .root      (q1_s),
    .out_side  (q1_side)
  );

  assign e1_in.f = q1_side.f;
  assign e1_in.c = q1_side.c;
  assign e1_in.s = q1_s;

  iks_cordic #(.SW($bits(elb_t))) u_cordic_elbow (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q1_v),
    .ys        ($signed({1'b0, q1_s})),
    .xs        (q1_side.c),
    .in_side   (e1_in),
    .out_valid (e1_v),
    .angle     (e1_ang),
    .out_side  (e1_side)
  );

  // Stages C1 to C4: x*(L1 + L2*c) - y*L2*s in Q.14 scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      vc1 <= 1'b0;
      vc2 <= 1'b0;
      vc3 <= 1'b0;
      vc4 <= 1'b0;
    end else if (en) begin
      vc1 <= e1_v;
      vc2 <= vc1;
      vc3 <= vc2;
      vc4 <= vc3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bc1.x        <= e1_side.f.x;
      bc1.y        <= e1_side.f.y;
      bc1.ms       <= e1_side.f.ms;
      bc1.me       <= e1_side.f.me;
      bc1.reach_ok <= e1_side.f.reach_ok;
      bc1.rz       <= e1_side.f.r2 == '0;
      bc1.elbow    <= e1_side.f.reach_ok ? -e1_ang : 16'sd0;
      r2c1         <= e1_side.f.r2;
      p1c1         <= $signed({1'b0, l2}) * e1_side.c;
      p2c1         <= l2 * e1_side.s;

      bc2  <= bc1;
      r2c2 <= r2c1;
      kc2  <= $signed({4'b0, l1, 14'b0}) + p1c1;
      p2c2 <= p2c1;

      bc3  <= bc2;
      r2c3 <= r2c2;
      ac3  <= bc2.x * kc2;
      bpc3 <= bc2.y * $signed({1'b0, p2c2});

      bc4   <= bc3;
      numc4 <= ac3 - bpc3;
    end
  end

  // The divisor passes through C4 unchanged from C3.
  logic [31:0] r2c4;
  always_ff @(posedge clk) begin
    if (en) begin
      r2c4 <= r2c3;
    end
  end

  iks_div #(.NW(48), .DW(32), .SW($bits(back_t))) u_div_shoulder (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc4),
    .num       (numc4),
    .den       (r2c4),
    .in_side   (bc4),
    .out_valid (d2_v),
    .quo       (d2_t),
    .out_side  (d2_side)
  );

  assign q2_in.b = d2_side;
  assign q2_in.t = d2_t;

  iks_sqrt #(.SW($bits(tb_t))) u_sqrt_shoulder (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2_v),
    .cosv      (d2_t),
    .in_side   (q2_in),
    .out_valid (q2_v),
    .root      (q2_s),
    .out_side  (q2_side)
  );

  // Out of reach the same unit points the stretched arm at the target.
  assign e2_ys = q2_side.b.reach_ok ? $signed({1'b0, q2_s}) : q2_side.b.y;
  assign e2_xs = q2_side.b.reach_ok ? q2_side.t : q2_side.b.x;

  iks_cordic #(.SW($bits(back_t))) u_cordic_shoulder (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q2_v),
    .ys        (e2_ys),
    .xs        (e2_xs),
    .in_side   (q2_side.b),
    .out_valid (e2_v),
    .angle     (e2_ang),
    .out_side  (e2_side)
  );

  // A target at the origin inside reach leaves the shoulder at zero.
  assign shoulder = (e2_side.reach_ok && e2_side.rz) ? 16'sd0 : e2_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0;
      vd2 <= 1'b0;
      vd3 <= 1'b0;
    end else if (en) begin
      vd1 <= e2_v;
      vd2 <= vd1;
      vd3 <= vd2;
    end
  end

  assign rnd1 = (pr1_d2 + 34'sd4096) >>> 13;
  assign rnd2 = (pr2_d2 + 34'sd4096) >>> 13;

  always_ff @(posedge clk) begin
    if (en) begin
      sh_d1  <= shoulder;
      el_d1  <= e2_side.elbow;
      in_d1  <= e2_side.reach_ok;
      er1_d1 <= {shoulder[15], shoulder} - {e2_side.ms[15], e2_side.ms};
      er2_d1 <= {e2_side.elbow[15], e2_side.elbow} - {e2_side.me[15], e2_side.me};

      sh_d2  <= sh_d1;
      el_d2  <= el_d1;
      in_d2  <= in_d1;
      pr1_d2 <= $signed({1'b0, gain}) * er1_d1;
      pr2_d2 <= $signed({1'b0, gain}) * er2_d1;

      sh_d3 <= sh_d2;
      el_d3 <= el_d2;
      in_d3 <= in_d2;
      if (rnd1 > 34'sd32767) begin
        sp1_d3 <= 16'sh7FFF;
      end else if (rnd1 < -34'sd32768) begin
        sp1_d3 <= -16'sh8000;
      end else begin
        sp1_d3 <= rnd1[15:0];
      end
      if (rnd2 > 34'sd32767) begin
        sp2_d3 <= 16'sh7FFF;
      end else if (rnd2 < -34'sd32768) begin
        sp2_d3 <= -16'sh8000;
      end else begin
        sp2_d3 <= rnd2[15:0];
      end
    end
  end

  assign m_axis_tvalid = vd3;
  assign m_axis_tdata  = {7'b0, sp2_d3, sp1_d3, in_d3, el_d3, sh_d3};

endmodule

>>> rtl/iks_div.sv
module iks_div import iks_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [15:0]   quo,
  output logic [SW-1:0]        out_side
);

  localparam int RW = (NW > DW + DIV_STEPS) ? NW : DW + DIV_STEPS;

  logic [NW-1:0] mag0;
  logic          neg0;
  logic [DW-1:0] den0;
  logic [SW-1:0] side0;
  logic          v0;

  logic [RW-1:0]        rem_q  [DIV_STEPS+1];
  logic [DW-1:0]        den_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q  [DIV_STEPS+1];
  logic                 neg_q  [DIV_STEPS+1];
  logic                 sat_q  [DIV_STEPS+1];
  logic [SW-1:0]        side_q [DIV_STEPS+1];
  logic                 vld_q  [DIV_STEPS+1];

  logic [DIV_STEPS-1:0] mq;

  // Magnitude and sign first; the quotient truncates toward zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0  <= num[NW-1] ? NW'(-num) : NW'(num);
      neg0  <= num[NW-1];
      den0  <= den;
      side0 <= in_side;
    end
  end

  // A quotient above one in Q.14, or a zero divisor, is clamped to one.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= RW'(mag0);
      den_q[0]  <= den0;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg0 && (den0 != '0);
      sat_q[0]  <= (RW'(mag0) >= (RW'(den0) << DIV_STEPS)) || (den0 == '0);
      side_q[0] <= side0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int B = DIV_STEPS - 1 - j;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(den_q[j]) << B;
    assign ge    = rem_q[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else if (en) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1]  <= ge ? rem_q[j] - trial : rem_q[j];
        quo_q[j+1]  <= quo_q[j] | (ge ? (DIV_STEPS'(1) << B) : '0);
        den_q[j+1]  <= den_q[j];
        neg_q[j+1]  <= neg_q[j];
        sat_q[j+1]  <= sat_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  always_comb begin
    if (sat_q[DIV_STEPS] || (quo_q[DIV_STEPS] > DIV_STEPS'(ONE_Q14))) begin
      mq = DIV_STEPS'(ONE_Q14);
    end else begin
      mq = quo_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= neg_q[DIV_STEPS] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
      out_side <= side_q[DIV_STEPS];
    end
  end

endmodule

>>> rtl/iks_sqrt.sv
module iks_sqrt import iks_pkg::*; #(
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] cosv,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [14:0]        root,
  output logic [SW-1:0]      out_side
);

  // Gives floor(sqrt(1 - cos^2)) in Q.14, one result bit per stage.
  logic signed [31:0] sq;
  logic [28:0]        csq0;
  logic [SW-1:0]      side0;
  logic               v0;

  logic [28:0]   rem_q  [SQRT_STEPS+1];
  logic [14:0]   root_q [SQRT_STEPS+1];
  logic [SW-1:0] side_q [SQRT_STEPS+1];
  logic          vld_q  [SQRT_STEPS+1];

  assign sq = cosv * cosv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      csq0  <= sq[28:0];
      side0 <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= 29'(ONE_Q14 * ONE_Q14) - csq0;
      root_q[0] <= '0;
      side_q[0] <= side0;
    end
  end

  // The remainder holds the argument minus the square of the root so far.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int B = SQRT_STEPS - 1 - j;
    logic [30:0] trial;
    logic        ge;

    assign trial = (31'(root_q[j]) << (B + 1)) + (31'd1 << (2 * B));
    assign ge    = 31'(rem_q[j]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j+1] <= 1'b0;
      end else if (en) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1]  <= ge ? 29'(31'(rem_q[j]) - trial) : rem_q[j];
        root_q[j+1] <= root_q[j] | (ge ? (15'd1 << B) : 15'd0);
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign out_valid = vld_q[SQRT_STEPS];
  assign root      = root_q[SQRT_STEPS];
  assign out_side  = side_q[SQRT_STEPS];

endmodule

>>> rtl/iks_cordic.sv
module iks_cordic import iks_pkg::*; #(
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] ys,
  input  logic signed [15:0] xs,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [15:0] angle,
  output logic [SW-1:0]      out_side
);

  logic signed [XY_W-1:0] xin, yin;
  logic signed [Z_W-1:0]  rnd;

  logic signed [XY_W-1:0] x_q    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_q    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q    [CORDIC_STEPS+1];
  logic                   zero_q [CORDIC_STEPS+1];
  logic [SW-1:0]          side_q [CORDIC_STEPS+1];
  logic                   vld_q  [CORDIC_STEPS+1];

  assign xin = {{(XY_W-32){xs[15]}}, xs, 16'b0};
  assign yin = {{(XY_W-32){ys[15]}}, ys, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  // A vector in the left half plane is turned by pi first.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_q[0] <= (xs == '0) && (ys == '0);
      side_q[0] <= in_side;
      if (xs[15]) begin
        x_q[0] <= -xin;
        y_q[0] <= -yin;
        z_q[0] <= ys[15] ? -PI_Q20 : PI_Q20;
      end else begin
        x_q[0] <= xin;
        y_q[0] <= yin;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] dx, dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_Q20[i];
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_Q20[i];
        end
      end
    end
  end

  assign rnd = (z_q[CORDIC_STEPS] + 25'sd64) >>> 7;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle    <= zero_q[CORDIC_STEPS] ? 16'sd0 : rnd[15:0];
      out_side <= side_q[CORDIC_STEPS];
    end
  end

endmodule

>>> rtl/iks_checker.sv
module iks_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // A result that waits is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The input side only waits while a result is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output stall");

  // The stretched arm has a straight elbow.
  a_out_elbow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:16] == 16'h0000)
    else $error("elbow not zero out of reach");

  // Inside reach the elbow bends down or lies straight and the shoulder is not negative.
  a_in_angles: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |->
      !m_axis_tdata[15] && (m_axis_tdata[31] || m_axis_tdata[31:16] == 16'h0000))
    else $error("inside reach angle out of range");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind two_link_ik_position_servo iks_checker u_iks_checker (.*);
